### hw/rtl/mash_pkg.sv
package mash_pkg;

   // Hash algorithm select codes
   typedef enum logic [3:0] {
      ALG_BKDR = 4'd0,
      ALG_BP   = 4'd1,
      ALG_DEK  = 4'd2,
      ALG_DJB  = 4'd3,
      ALG_ELF  = 4'd4,
      ALG_FNV  = 4'd5,
      ALG_JS   = 4'd6,
      ALG_PJW  = 4'd7,
      ALG_RS   = 4'd8,
      ALG_SDBM = 4'd9
   } alg_type;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned BYTE_W = 8;

   localparam logic [HASH_W-1:0] BKDR_SEED   = 32'd131;
   localparam logic [HASH_W-1:0] DJB_START   = 32'd5381;
   localparam logic [HASH_W-1:0] ELF_TOP     = 32'hF000_0000;
   localparam logic [HASH_W-1:0] FNV_MUL     = 32'h811C_9DC5;
   localparam logic [HASH_W-1:0] JS_START    = 32'd1315423911;
   localparam logic [HASH_W-1:0] RS_MUL_STEP = 32'd378551;
   localparam logic [HASH_W-1:0] RS_MUL_INIT = 32'd63689;
   localparam int unsigned       DEK_ROT     = 27;

endpackage

### hw/rtl/multi_algorithm_string_hash.sv
// Streaming string hash. Key bytes arrive one word per cycle on req_ (tuser marks the
// first byte, tlast the last); the 32-bit hash of the key leaves on rsp_ after the last
// byte. csr_data selects the algorithm (0 BKDR, 1 BP, 2 DEK, 3 DJB, 4 ELF, 5 FNV, 6 JS,
// 7 PJW, 8 RS, 9 SDBM; other codes hold the hash, zeroed on a first byte); the user must
// write it only while the block is idle, which the block does not enforce. Bytes are
// sign-extended to 32 bits and all arithmetic wraps modulo 2^32. DEK is seeded with the
// key length carried with the first byte. Throughput is one byte per cycle: each byte is
// held in an input register and folded into the hash by at most one 32x32 multiply plus
// the RS factor multiply; the block stalls only while a finished hash waits on rsp_.
module multi_algorithm_string_hash
   import mash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data,     // algorithm
   // key byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [7:0] data_byte, [23:8] key_length
   input  logic        req_tuser,    // [0] first_byte
   input  logic        req_tlast,    // last_byte
   // hash result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [31:0] hash_value
);

   logic [3:0]        alg_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [LEN_W-1:0]  in_len_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] rsf_ff, rsf_in;
   logic              out_valid_ff;
   logic [HASH_W-1:0] out_hash_ff;

   logic              out_free;
   logic              proc_fire;
   logic [HASH_W-1:0] c_ext;
   logic [HASH_W-1:0] h0;
   logic [HASH_W-1:0] mul_op;
   logic [HASH_W-1:0] prod;
   logic [HASH_W-1:0] shl4;
   logic [HASH_W-1:0] top;

   // handshake
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign proc_fire  = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || proc_fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_hash_ff;

   // algorithm register
   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff <= ALG_BKDR;
      end else if (csr_valid && csr_ready) begin
         alg_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[7:0];
         in_len_ff   <= req_tdata[23:8];
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   // starting state: reseeded on the first byte of a key
   assign c_ext = {{(HASH_W-BYTE_W){in_byte_ff[BYTE_W-1]}}, in_byte_ff};

   always_comb begin
      h0 = hash_ff;
      if (in_first_ff) begin
         case (alg_ff)
            ALG_DEK: h0 = {{(HASH_W-LEN_W){1'b0}}, in_len_ff};
            ALG_DJB: h0 = DJB_START;
            ALG_JS:  h0 = JS_START;
            default: h0 = '0;
         endcase
      end
   end

   // one shared multiplier for BKDR, FNV and RS
   always_comb begin
      case (alg_ff)
         ALG_BKDR: mul_op = BKDR_SEED;
         ALG_FNV:  mul_op = FNV_MUL;
         default:  mul_op = in_first_ff ? RS_MUL_INIT : rsf_ff;
      endcase
   end

   assign prod   = h0 * mul_op;
   assign rsf_in = (in_first_ff ? RS_MUL_INIT : rsf_ff) * RS_MUL_STEP;
   assign shl4   = (h0 << 4) + c_ext;
   assign top    = shl4 & ELF_TOP;

   // hash mix
   always_comb begin
      case (alg_ff)
         ALG_BKDR: hash_in = prod + c_ext;
         ALG_BP:   hash_in = (h0 << 7) ^ c_ext;
         ALG_DEK:  hash_in = ((h0 << 5) ^ (h0 >> DEK_ROT)) ^ c_ext;
         ALG_DJB:  hash_in = ((h0 << 5) + h0) + c_ext;
         ALG_ELF:  hash_in = (shl4 ^ (top >> 24)) & ~top;
         ALG_FNV:  hash_in = prod ^ c_ext;
         ALG_JS:   hash_in = h0 ^ ((h0 << 5) + c_ext + (h0 >> 2));
         ALG_PJW:  hash_in = (top != '0) ? ((shl4 ^ (top >> 24)) & ~ELF_TOP) : shl4;
         ALG_RS:   hash_in = prod + c_ext;
         ALG_SDBM: hash_in = c_ext + (h0 << 6) + (h0 << 16) - h0;
         default:  hash_in = h0;
      endcase
   end

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         rsf_ff  <= RS_MUL_INIT;
      end else if (proc_fire) begin
         hash_ff <= hash_in;
         rsf_ff  <= rsf_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && in_last_ff) begin
         out_hash_ff <= hash_in;
      end
   end

endmodule

### tb/sv/hash_stream_checker.sv
`timescale 1ns / 1ps

// Watches the csr, key byte and hash channels, predicts each hash and
// compares it with what leaves the block.
module hash_stream_checker
   import mash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_data,       // algorithm
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,      // [7:0] data_byte, [23:8] key_length
   input  logic        req_tuser,      // [0] first_byte
   input  logic        req_tlast,      // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,      // [31:0] hash_value
   output int unsigned hashes_pending,
   output int unsigned mismatches
);

   logic [3:0]        cur_alg;
   logic [HASH_W-1:0] run_hash;
   logic [HASH_W-1:0] rs_mult;
   logic [HASH_W-1:0] expected_hashes[$];

   initial begin
      mismatches     = 0;
      hashes_pending = 0;
   end

   // One step of the selected hash; c is the sign-extended byte
   function automatic logic [HASH_W-1:0] fold_byte(input logic [3:0] alg,
                                                   input logic [HASH_W-1:0] h,
                                                   input logic [HASH_W-1:0] c,
                                                   input logic [HASH_W-1:0] rsf);
      logic [HASH_W-1:0] x;
      logic [HASH_W-1:0] t;
      case (alg)
         ALG_BKDR: fold_byte = h * BKDR_SEED + c;
         ALG_BP:   fold_byte = (h << 7) ^ c;
         ALG_DEK:  fold_byte = ((h << 5) ^ (h >> DEK_ROT)) ^ c;
         ALG_DJB:  fold_byte = (h << 5) + h + c;
         ALG_ELF: begin
            x = (h << 4) + c;
            t = x & ELF_TOP;
            if (t != '0) x = x ^ (t >> 24);
            fold_byte = x & ~t;
         end
         ALG_FNV:  fold_byte = (h * FNV_MUL) ^ c;
         ALG_JS:   fold_byte = h ^ ((h << 5) + c + (h >> 2));
         ALG_PJW: begin
            x = (h << 4) + c;
            t = x & ELF_TOP;
            if (t != '0) x = (x ^ (t >> 24)) & ~ELF_TOP;
            fold_byte = x;
         end
         ALG_RS:   fold_byte = h * rsf + c;
         ALG_SDBM: fold_byte = c + (h << 6) + (h << 16) - h;
         // unused codes hold the hash
         default:  fold_byte = h;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      logic [HASH_W-1:0] sext;
      logic [HASH_W-1:0] want;
      if (reset) begin
         cur_alg  = ALG_BKDR;
         run_hash = '0;
         rs_mult  = RS_MUL_INIT;
         expected_hashes.delete();
      end else begin
         if (csr_valid && csr_ready) cur_alg = csr_data;

         // outgoing hash word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch($sformatf("hash %h arrived with none pending", rsp_tdata));
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("hash %h, predicted %h", rsp_tdata, want));
            end
         end

         // accepted key byte word
         if (req_tvalid && req_tready) begin
            sext = {{(HASH_W-BYTE_W){req_tdata[BYTE_W-1]}}, req_tdata[BYTE_W-1:0]};
            if (req_tuser) begin
               case (cur_alg)
                  ALG_DEK: run_hash = {{(HASH_W-LEN_W){1'b0}}, req_tdata[23:8]};
                  ALG_DJB: run_hash = DJB_START;
                  ALG_JS:  run_hash = JS_START;
                  default: run_hash = '0;
               endcase
               rs_mult = RS_MUL_INIT;
            end
            run_hash = fold_byte(cur_alg, run_hash, sext, rs_mult);
            // RS factor moves on every byte, whatever the algorithm
            rs_mult  = rs_mult * RS_MUL_STEP;
            if (req_tlast) expected_hashes.push_back(run_hash);
         end
      end
      hashes_pending = expected_hashes.size();
   end

endmodule

### tb/sv/tb_multi_algorithm_string_hash.sv
`timescale 1ns / 1ps

module tb_multi_algorithm_string_hash;
   import mash_pkg::*;

   localparam int unsigned RANDOM_BYTES = 1500;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data   = '0;    // algorithm
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [7:0] data_byte, [23:8] key_length
   logic        req_tuser  = 1'b0;  // [0] first_byte
   logic        req_tlast  = 1'b0;  // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] hash_value

   int unsigned hashes_pending;
   int unsigned mismatches;
   int unsigned bytes_sent = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   multi_algorithm_string_hash DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hash_stream_checker u_hash_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .hashes_pending (hashes_pending),
      .mismatches     (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hash receiver: picks a new back-pressure mode each time its stall counter runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_left % 8 == 0);
      endcase
   end

   // One key byte word; bursts end in a random gap
   task automatic push_byte(input logic [7:0] data_byte, input bit is_first,
                            input bit is_last, input logic [15:0] key_len);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {key_len, data_byte};
      req_tuser  <= is_first;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
      end
   endtask

   // Stop sending and let every pending hash drain, plus pipeline latency
   task automatic wait_hashes_done();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hashes_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_algorithm(input logic [3:0] alg);
      wait_hashes_done();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= alg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Key of n random bytes; start or end marker may be left off
   task automatic send_key(input int n, input logic [15:0] key_len,
                           input bit with_first, input bit with_last);
      int i;
      for (i = 0; i < n; i++)
         push_byte(8'($urandom_range(0, 255)), with_first && (i == 0),
                   with_last && (i == n - 1),
                   (i == 0) ? key_len : 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int          a;
      int          n;
      int          kind;
      int          phase;
      logic [3:0]  alg;
      logic [15:0] key_len;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no key start since reset: continues from reset state
      push_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF);
      push_byte(8'h7F, 1'b0, 1'b1, 16'h0000);

      // one two-byte key per algorithm, sign extremes on the byte
      for (a = 0; a < 10; a++) begin
         set_algorithm(a[3:0]);
         push_byte(a[0] ? 8'h80 : 8'hFF, 1'b1, 1'b0, a[0] ? 16'hFFFF : 16'h0000);
         push_byte(a[0] ? 8'h00 : 8'h7F, 1'b0, 1'b1, 16'hFFFF);
      end

      // unused codes hold the hash (zeroed on a key start); single-byte key and a bare last byte
      set_algorithm(4'd12);
      push_byte(8'h55, 1'b1, 1'b1, 16'h1234);
      set_algorithm(4'd15);
      push_byte(8'hAA, 1'b0, 1'b1, 16'h0000);

      // algorithm switched in the middle of a key
      set_algorithm(ALG_DEK);
      push_byte(8'h31, 1'b1, 1'b0, 16'd3);
      set_algorithm(ALG_FNV);
      push_byte(8'hC3, 1'b0, 1'b1, 16'h0000);

      // random phases, one algorithm each
      bytes_sent = 0;
      phase = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         case (phase)
            0:       alg = ALG_BKDR;
            1:       alg = ALG_SDBM;
            2:       alg = 4'd15;
            default: alg = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                       : 4'($urandom_range(0, 9));
         endcase
         set_algorithm(alg);
         repeat ($urandom_range(3, 10)) begin
            kind = $urandom_range(0, 9);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            key_len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'(n);
            if (kind < 8)
               send_key(n, key_len, 1'b1, 1'b1);
            else if (kind == 8)
               send_key(n, key_len, 1'b0, 1'b1);   // runs on from previous hash
            else
               send_key(n, key_len, 1'b1, 1'b0);   // abandoned key
            // occasional full drain between keys
            if ($urandom_range(0, 15) == 0) wait_hashes_done();
         end
         phase++;
      end

      wait_hashes_done();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
